### hdl/tone_effect_sequencer_macros.svh
// assertion macros for the tone effect sequencer checker
// used by tes_checker.sv; no other dependencies
`ifndef TONE_EFFECT_SEQUENCER_MACROS_SVH
`define TONE_EFFECT_SEQUENCER_MACROS_SVH

// same-cycle implication, ignored during reset
`define TES_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tes check failed");

// next-cycle implication, ignored during reset
`define TES_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tes check failed");

`endif

### hdl/tes_pkg.sv
// shared types and constants for the tone effect sequencer
// no dependencies; imported by every other file but the macro header
package tes_pkg;

  localparam int OP_W   = 2;
  localparam int FX_W   = 4;
  localparam int PRI_W  = 8;
  localparam int DIV_W  = 16;
  localparam int FRM_W  = 4;
  localparam int PHS_W  = 4;

  localparam logic [FX_W-1:0] NUM_EFFECTS = 4'd12;

  typedef enum logic [OP_W-1:0] {
    OP_PLAY = 2'd0,
    OP_TICK = 2'd1,
    OP_STOP = 2'd2
  } op_t;

  // one note lookup: divisor and frame count, or end of effect
  typedef struct packed {
    logic             quiet;
    logic [DIV_W-1:0] divisor;
    logic [FRM_W-1:0] frames;
  } note_t;

endpackage

### hdl/tes_ifaces.sv
// valid/ready channel interfaces for request and result items
// depends on tes_pkg
interface tes_req_if;
  import tes_pkg::*;
  logic              valid;
  logic              ready;
  op_t               op;
  logic [FX_W-1:0]   effect_id;
  logic [PRI_W-1:0]  request_priority;

  modport source (output valid, op, effect_id, request_priority, input ready);
  modport sink   (input valid, op, effect_id, request_priority, output ready);
endinterface

interface tes_rsp_if;
  import tes_pkg::*;
  logic              valid;
  logic              ready;
  logic              tone_on;
  logic [DIV_W-1:0]  timer_divisor;
  logic [PRI_W-1:0]  busy_priority;

  modport source (output valid, tone_on, timer_divisor, busy_priority, input ready);
  modport sink   (input valid, tone_on, timer_divisor, busy_priority, output ready);
endinterface

### hdl/tes_note_rom.sv
// note tables: first note of an effect and the note after a phase step
// depends on tes_pkg; divisors are 1193180 / f, truncated
module tes_note_rom (
  input  logic [tes_pkg::FX_W-1:0]  start_effect,
  input  logic [tes_pkg::FX_W-1:0]  adv_effect,
  input  logic [tes_pkg::PHS_W-1:0] adv_phase,
  output tes_pkg::note_t            start_note,
  output tes_pkg::note_t            adv_note
);
  import tes_pkg::*;

  localparam logic [FX_W-1:0] FX_FIRE  = 4'd4;
  localparam logic [FX_W-1:0] FX_BOOM  = 4'd5;
  localparam logic [FX_W-1:0] FX_DEATH = 4'd6;
  localparam logic [FX_W-1:0] FX_UFO   = 4'd7;
  localparam logic [FX_W-1:0] FX_HIT   = 4'd8;
  localparam logic [FX_W-1:0] FX_CLEAR = 4'd10;
  localparam logic [FX_W-1:0] FX_TITLE = 4'd11;

  always_comb begin
    start_note.quiet = 1'b0;
    case (start_effect)
      4'd0:    begin start_note.divisor = 16'd7457;  start_note.frames = 4'd4;  end
      4'd1:    begin start_note.divisor = 16'd9178;  start_note.frames = 4'd4;  end
      4'd2:    begin start_note.divisor = 16'd11931; start_note.frames = 4'd4;  end
      4'd3:    begin start_note.divisor = 16'd14914; start_note.frames = 4'd4;  end
      4'd4:    begin start_note.divisor = 16'd3977;  start_note.frames = 4'd6;  end
      4'd5:    begin start_note.divisor = 16'd14914; start_note.frames = 4'd8;  end
      4'd6:    begin start_note.divisor = 16'd1491;  start_note.frames = 4'd10; end
      4'd7:    begin start_note.divisor = 16'd5965;  start_note.frames = 4'd1;  end
      4'd8:    begin start_note.divisor = 16'd5965;  start_note.frames = 4'd4;  end
      4'd9:    begin start_note.divisor = 16'd9943;  start_note.frames = 4'd2;  end
      4'd10:   begin start_note.divisor = 16'd3615;  start_note.frames = 4'd8;  end
      4'd11:   begin start_note.divisor = 16'd3615;  start_note.frames = 4'd12; end
      default: begin start_note.divisor = '0;        start_note.frames = '0;    end
    endcase
  end

  // note for the new phase; single-note effects end here
  always_comb begin
    adv_note.quiet   = 1'b0;
    adv_note.divisor = '0;
    adv_note.frames  = 4'd1;
    case (adv_effect)
      FX_FIRE: begin
        case (adv_phase)
          4'd1:    adv_note.divisor = 16'd2169;
          4'd2:    adv_note.divisor = 16'd1491;
          4'd3:    adv_note.divisor = 16'd1084;
          4'd4:    adv_note.divisor = 16'd795;
          4'd5:    adv_note.divisor = 16'd596;
          4'd0:    adv_note.divisor = 16'd3977;
          default: adv_note.quiet = 1'b1;
        endcase
      end
      FX_BOOM: begin
        adv_note.quiet   = adv_phase[3];
        adv_note.divisor = adv_phase[0] ? 16'd3977 : 16'd14914;
      end
      FX_DEATH: begin
        adv_note.frames = 4'd10;
        case (adv_phase)
          4'd0:    adv_note.divisor = 16'd1491;
          4'd1:    adv_note.divisor = 16'd1835;
          4'd2:    adv_note.divisor = 16'd2386;
          4'd3:    adv_note.divisor = 16'd3139;
          4'd4:    adv_note.divisor = 16'd4419;
          4'd5:    adv_note.divisor = 16'd6628;
          default: adv_note.quiet = 1'b1;
        endcase
      end
      FX_UFO: begin
        adv_note.divisor = adv_phase[0] ? 16'd7018 : 16'd5965;
      end
      FX_HIT: begin
        adv_note.frames = 4'd4;
        case (adv_phase)
          4'd0:    adv_note.divisor = 16'd5965;
          4'd1:    adv_note.divisor = 16'd4261;
          4'd2:    adv_note.divisor = 16'd3139;
          4'd3:    adv_note.divisor = 16'd2386;
          default: adv_note.quiet = 1'b1;
        endcase
      end
      FX_CLEAR: begin
        adv_note.frames = 4'd8;
        case (adv_phase)
          4'd0:    adv_note.divisor = 16'd3615;
          4'd1:    adv_note.divisor = 16'd2711;
          4'd2:    adv_note.divisor = 16'd2281;
          4'd3:    adv_note.divisor = 16'd1810;
          4'd4:    adv_note.divisor = 16'd1521;
          4'd5:    adv_note.divisor = 16'd1139;
          default: adv_note.quiet = 1'b1;
        endcase
      end
      FX_TITLE: begin
        adv_note.frames = 4'd12;
        case (adv_phase[2:0])
          3'd0:    adv_note.divisor = 16'd3615;
          3'd1:    adv_note.divisor = 16'd3043;
          3'd2:    adv_note.divisor = 16'd2415;
          3'd3:    adv_note.divisor = 16'd2281;
          3'd4:    adv_note.divisor = 16'd2711;
          3'd5:    adv_note.divisor = 16'd3043;
          3'd6:    adv_note.divisor = 16'd3615;
          default: adv_note.divisor = 16'd4554;
        endcase
      end
      default: adv_note.quiet = 1'b1;
    endcase
  end

endmodule

### hdl/tes_seq_state.sv
// sequencer state registers and their update per request
// depends on tes_pkg and tes_note_rom
module tes_seq_state (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  tes_pkg::op_t               op,
  input  logic [tes_pkg::FX_W-1:0]   effect_id,
  input  logic [tes_pkg::PRI_W-1:0]  request_priority,
  output logic                       gate_reg,
  output logic [tes_pkg::DIV_W-1:0]  divisor_reg,
  output logic [tes_pkg::PRI_W-1:0]  current_priority
);
  import tes_pkg::*;

  logic [FX_W-1:0]  current_effect, current_effect_next;
  logic [PHS_W-1:0] note_phase, note_phase_next;
  logic [FRM_W-1:0] frames_left, frames_left_next;
  logic [DIV_W-1:0] divisor_reg_next;
  logic [PRI_W-1:0] current_priority_next;
  logic             gate_reg_next;
  logic [PHS_W-1:0] phase_inc;
  logic [FRM_W-1:0] frames_dec;
  note_t            start_note, adv_note;

  assign phase_inc  = note_phase + PHS_W'(1);
  assign frames_dec = frames_left - FRM_W'(1);

  tes_note_rom u_rom (
    .start_effect (effect_id),
    .adv_effect   (current_effect),
    .adv_phase    (phase_inc),
    .start_note   (start_note),
    .adv_note     (adv_note)
  );

  always_comb begin
    current_priority_next = current_priority;
    current_effect_next   = current_effect;
    note_phase_next       = note_phase;
    frames_left_next      = frames_left;
    divisor_reg_next      = divisor_reg;
    gate_reg_next         = gate_reg;
    case (op)
      OP_PLAY: begin
        // a valid effect on an idle channel or with equal/better priority takes over
        if (effect_id < NUM_EFFECTS &&
            (current_priority == '0 || request_priority <= current_priority)) begin
          current_priority_next = request_priority;
          current_effect_next   = effect_id;
          note_phase_next       = '0;
          divisor_reg_next      = start_note.divisor;
          gate_reg_next         = 1'b1;
          frames_left_next      = start_note.frames;
        end
      end
      OP_TICK: begin
        if (frames_left != '0) begin
          frames_left_next = frames_dec;
          if (frames_dec == '0) begin
            note_phase_next = phase_inc;
            if (adv_note.quiet) begin
              gate_reg_next         = 1'b0;
              current_priority_next = '0;
            end else begin
              divisor_reg_next = adv_note.divisor;
              gate_reg_next    = 1'b1;
              frames_left_next = adv_note.frames;
            end
          end
        end
      end
      OP_STOP: begin
        gate_reg_next         = 1'b0;
        current_priority_next = '0;
        frames_left_next      = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_priority <= '0;
      current_effect   <= '0;
      note_phase       <= '0;
      frames_left      <= '0;
      divisor_reg      <= '0;
      gate_reg         <= 1'b0;
    end else if (step) begin
      current_priority <= current_priority_next;
      current_effect   <= current_effect_next;
      note_phase       <= note_phase_next;
      frames_left      <= frames_left_next;
      divisor_reg      <= divisor_reg_next;
      gate_reg         <= gate_reg_next;
    end
  end

endmodule

### hdl/tone_effect_sequencer.sv
// square-wave tone effect sequencer, top level
// depends on tes_pkg, tes_ifaces, tes_seq_state
//
// usage:
//   item   : request channel; op is play, frame tick or stop, with effect
//            number and priority for play (lower number wins, 0 is idle)
//   result : one response per request, carrying the gate state, the timer
//            divisor now programmed and the priority of the playing effect
//   a request is taken into an input register, and it updates the sequencer
//   state once the response register can take a new value; the state
//   registers hold the response, which is valid after that update
//   throughput is one request per cycle while the receiver does not stall,
//   set by the update loop on the state registers
//   when the receiver stalls the response and the state hold, the input
//   register still takes one more request, and then ready drops
//   reset (rst, synchronous) empties both stages, silences the gate, clears
//   the divisor and marks the channel idle
module tone_effect_sequencer (
  input  logic      clk,
  input  logic      rst,
  tes_req_if.sink   item,
  tes_rsp_if.source result
);
  import tes_pkg::*;

  logic             in_valid;
  op_t              in_op;
  logic [FX_W-1:0]  in_effect;
  logic [PRI_W-1:0] in_priority;
  logic             out_valid;
  logic             step;

  // state advances when a request is held and the response register can take a new value
  assign step       = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (item.ready) begin
        in_valid <= item.valid;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_op       <= item.op;
      in_effect   <= item.effect_id;
      in_priority <= item.request_priority;
    end
  end

  tes_seq_state u_state (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .op               (in_op),
    .effect_id        (in_effect),
    .request_priority (in_priority),
    .gate_reg         (result.tone_on),
    .divisor_reg      (result.timer_divisor),
    .current_priority (result.busy_priority)
  );

  assign result.valid = out_valid;

endmodule

### hdl/tes_checker.sv
// port-level checks for the tone effect sequencer, bound to the top level
// depends on tes_pkg and tone_effect_sequencer_macros.svh
`include "tone_effect_sequencer_macros.svh"

module tes_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      tone_on,
  input logic [tes_pkg::DIV_W-1:0] timer_divisor,
  input logic [tes_pkg::PRI_W-1:0] busy_priority
);
  import tes_pkg::*;

  // a held priority means an effect is sounding
  `TES_ASSERT_IMPL(a_busy_sounds, clk, rst, out_valid && busy_priority != '0, tone_on)
  // a sounding gate always has a programmed divisor
  `TES_ASSERT_IMPL(a_gate_divisor, clk, rst, out_valid && tone_on, timer_divisor != '0)
  // no response right after reset
  `TES_ASSERT_IMPL(a_reset_empty, clk, rst, $past(rst), !out_valid)
  // a stalled response is not withdrawn
  `TES_ASSERT_NEXT(a_hold_valid, clk, rst, out_valid && !out_ready, out_valid)

endmodule

bind tone_effect_sequencer tes_checker u_tes_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .tone_on       (result.tone_on),
  .timer_divisor (result.timer_divisor),
  .busy_priority (result.busy_priority)
);

### sim/tes_sound_checker.sv
// predicts and checks responses of the tone effect sequencer
// depends on tes_pkg and tes_ifaces; watches both channels, counts mismatches
module tes_sound_checker (
  input  logic clk,
  input  logic rst,
  tes_req_if   item,
  tes_rsp_if   result,
  output int   fails,
  output int   pending
);
  import tes_pkg::*;

  localparam int PIT_HZ = 1193180;

  localparam logic [FX_W-1:0] FX_FIRE    = 4'd4;
  localparam logic [FX_W-1:0] FX_BOOM    = 4'd5;
  localparam logic [FX_W-1:0] FX_DEATH   = 4'd6;
  localparam logic [FX_W-1:0] FX_UFO     = 4'd7;
  localparam logic [FX_W-1:0] FX_UFO_HIT = 4'd8;
  localparam logic [FX_W-1:0] FX_CLEAR   = 4'd10;
  localparam logic [FX_W-1:0] FX_TITLE   = 4'd11;

  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [FX_W-1:0]  fx;
    logic [PHS_W-1:0] phase;
    logic [FRM_W-1:0] frames;
    logic [DIV_W-1:0] divisor;
    logic             gate;
  } tone_state_t;

  typedef struct packed {
    logic             tone_on;
    logic [DIV_W-1:0] timer_divisor;
    logic [PRI_W-1:0] busy_priority;
  } tone_out_t;

  tone_state_t tone;
  tone_out_t   expected_tones[$];
  int          fail_count = 0;
  int          n_results = 0;

  assign fails   = fail_count;
  assign pending = expected_tones.size();

  function automatic int first_hz(logic [FX_W-1:0] fx);
    case (fx)
      4'd0: return 160;
      4'd1: return 130;
      4'd2: return 100;
      4'd3: return 80;
      4'd4: return 300;
      4'd5: return 80;
      4'd6: return 800;
      4'd7: return 200;
      4'd8: return 200;
      4'd9: return 120;
      default: return 330;
    endcase
  endfunction

  function automatic int first_frames(logic [FX_W-1:0] fx);
    case (fx)
      4'd4: return 6;
      4'd5: return 8;
      4'd6: return 10;
      4'd7: return 1;
      4'd9: return 2;
      4'd10: return 8;
      4'd11: return 12;
      default: return 4;
    endcase
  endfunction

  // note that follows a phase step; 0 Hz ends the effect
  function automatic int step_hz(logic [FX_W-1:0] fx, logic [PHS_W-1:0] ph);
    case (fx)
      FX_FIRE: begin
        case (ph)
          4'd1: return 550;
          4'd2: return 800;
          4'd3: return 1100;
          4'd4: return 1500;
          4'd5: return 2000;
          default: return (ph == 4'd0) ? 300 : 0;
        endcase
      end
      FX_BOOM:  return (ph < 4'd8) ? (ph[0] ? 300 : 80) : 0;
      FX_DEATH: begin
        case (ph)
          4'd0: return 800;
          4'd1: return 650;
          4'd2: return 500;
          4'd3: return 380;
          4'd4: return 270;
          4'd5: return 180;
          default: return 0;
        endcase
      end
      FX_UFO: return ph[0] ? 170 : 200;
      FX_UFO_HIT: begin
        case (ph)
          4'd0: return 200;
          4'd1: return 280;
          4'd2: return 380;
          4'd3: return 500;
          default: return 0;
        endcase
      end
      FX_CLEAR: begin
        case (ph)
          4'd0: return 330;
          4'd1: return 440;
          4'd2: return 523;
          4'd3: return 659;
          4'd4: return 784;
          4'd5: return 1047;
          default: return 0;
        endcase
      end
      FX_TITLE: begin
        case (ph[2:0])
          3'd0: return 330;
          3'd1: return 392;
          3'd2: return 494;
          3'd3: return 523;
          3'd4: return 440;
          3'd5: return 392;
          3'd6: return 330;
          default: return 262;
        endcase
      end
      default: return 0;
    endcase
  endfunction

  function automatic int step_frames(logic [FX_W-1:0] fx);
    case (fx)
      FX_DEATH:   return 10;
      FX_UFO_HIT: return 4;
      FX_CLEAR:   return 8;
      FX_TITLE:   return 12;
      default:    return 1;
    endcase
  endfunction

  function automatic tone_state_t play_note(tone_state_t s, int hz, int frm);
    s.divisor = DIV_W'(PIT_HZ / hz);
    s.gate    = 1'b1;
    s.frames  = FRM_W'(frm);
    return s;
  endfunction

  function automatic tone_state_t next_tone(tone_state_t s, op_t op,
                                            logic [FX_W-1:0] fx,
                                            logic [PRI_W-1:0] pri);
    int hz;
    case (op)
      OP_PLAY: begin
        if (fx < NUM_EFFECTS && (s.pri == '0 || pri <= s.pri)) begin
          s.pri   = pri;
          s.fx    = fx;
          s.phase = '0;
          s       = play_note(s, first_hz(fx), first_frames(fx));
        end
      end
      OP_TICK: begin
        if (s.frames != '0) begin
          s.frames = s.frames - 1'b1;
          if (s.frames == '0) begin
            s.phase = s.phase + 1'b1;
            hz = step_hz(s.fx, s.phase);
            if (hz == 0) begin
              s.gate = 1'b0;
              s.pri  = '0;
            end else begin
              s = play_note(s, hz, step_frames(s.fx));
            end
          end
        end
      end
      OP_STOP: begin
        s.gate   = 1'b0;
        s.pri    = '0;
        s.frames = '0;
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic report(string field, int want, int got);
    $display("mismatch on response %0d: %s expected %0h got %0h",
             n_results, field, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    tone_out_t want;
    if (rst) begin
      tone = '0;
      expected_tones.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (expected_tones.size() == 0) begin
          $display("unexpected response %0d", n_results);
          fail_count++;
        end else begin
          want = expected_tones.pop_front();
          if (result.tone_on !== want.tone_on)
            report("tone_on", want.tone_on, result.tone_on);
          if (result.timer_divisor !== want.timer_divisor)
            report("timer_divisor", want.timer_divisor, result.timer_divisor);
          if (result.busy_priority !== want.busy_priority)
            report("busy_priority", want.busy_priority, result.busy_priority);
        end
        n_results++;
      end
      if (item.valid && item.ready) begin
        tone = next_tone(tone, item.op, item.effect_id, item.request_priority);
        expected_tones.push_back({tone.gate, tone.divisor, tone.pri});
      end
    end
  end

endmodule

### sim/tone_effect_sequencer_tb.sv
// testbench top for the tone effect sequencer: clock, reset, requests, verdict
// depends on tes_pkg, tes_ifaces, tone_effect_sequencer and tes_sound_checker
module tone_effect_sequencer_tb;
  import tes_pkg::*;

  localparam op_t OP_SPARE = op_t'(2'd3);

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fails;
  int   pending;
  int   sent = 0;
  int   src_idle_pct = 19;
  int   snk_idle_pct = 46;
  int   stall_trigger = 0;

  tes_req_if item ();
  tes_rsp_if result ();

  tone_effect_sequencer uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result)
  );

  tes_sound_checker chk (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .result  (result),
    .fails   (fails),
    .pending (pending)
  );

  always #1 clk = ~clk;

  initial begin
    #200000;
    $display("simulation failed");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off when triggered
  initial begin
    int hold;
    int seen;
    hold = 0;
    seen = 0;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_trigger != seen) begin
        seen = stall_trigger;
        hold = 80;
      end
      if (hold > 0) begin
        hold--;
        result.ready <= 1'b0;
      end else begin
        result.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic send_req(input op_t op, input logic [FX_W-1:0] fx,
                          input logic [PRI_W-1:0] pri);
    logic took;
    while ($urandom_range(99) < src_idle_pct) begin
      item.valid <= 1'b0;
      @(posedge clk);
    end
    item.valid            <= 1'b1;
    item.op               <= op;
    item.effect_id        <= fx;
    item.request_priority <= pri;
    do begin
      @(negedge clk);
      took = item.ready;
      @(posedge clk);
    end while (!took);
    sent++;
  endtask

  task automatic tick_run(input int n);
    repeat (n) send_req(OP_TICK, FX_W'($urandom), PRI_W'($urandom));
  endtask

  function automatic logic [PRI_W-1:0] pick_priority();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return PRI_W'($urandom_range(1, 8));
      default: return PRI_W'($urandom);
    endcase
  endfunction

  task automatic drain();
    item.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    bit stalled;
    bit paused;
    stalled = 0;
    paused  = 0;
    item.valid            <= 1'b0;
    item.op               <= OP_TICK;
    item.effect_id        <= '0;
    item.request_priority <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part
    send_req(OP_TICK, 4'd0, 8'd0);        // tick with nothing playing
    send_req(OP_SPARE, 4'hf, 8'hff);      // unused op
    send_req(OP_PLAY, 4'd12, 8'd1);       // effect out of range
    send_req(OP_PLAY, 4'd15, 8'd0);
    send_req(OP_PLAY, 4'd0, 8'd255);
    send_req(OP_PLAY, 4'd3, 8'd255);      // equal priority takes over
    send_req(OP_PLAY, 4'd5, 8'd200);
    send_req(OP_PLAY, 4'd9, 8'd201);      // loses preemption
    tick_run(9);                          // explosion steps into its short notes
    send_req(OP_PLAY, 4'd7, 8'd0);        // zero priority, still sounds
    send_req(OP_PLAY, 4'd10, 8'd1);       // channel reads idle, so this starts
    send_req(OP_STOP, 4'd0, 8'd0);
    send_req(OP_TICK, 4'd0, 8'd0);
    send_req(OP_PLAY, 4'd9, 8'd1);
    tick_run(2);                          // single note ends, channel freed

    // random part: mostly a play followed by a run of frame ticks
    while (sent < 700) begin
      if (sent >= 230 && sent < 460) begin
        src_idle_pct <= 46;
        snk_idle_pct <= 19;
      end else if (sent >= 460) begin
        src_idle_pct <= 0;
        snk_idle_pct <= 0;
      end
      if (!stalled && sent >= 120) begin
        stalled = 1;
        stall_trigger <= stall_trigger + 1;
      end
      if (!paused && sent >= 350) begin
        paused = 1;
        drain();
      end
      if ($urandom_range(99) < 65) begin
        send_req(OP_PLAY, FX_W'($urandom_range(0, 11)), pick_priority());
        repeat ($urandom_range(1, 70)) begin
          case ($urandom_range(49))
            0: send_req(OP_PLAY, FX_W'($urandom), pick_priority());
            1: send_req(OP_STOP, FX_W'($urandom), PRI_W'($urandom));
            default: send_req(OP_TICK, FX_W'($urandom), PRI_W'($urandom));
          endcase
        end
      end else begin
        send_req(op_t'($urandom_range(0, 3)), FX_W'($urandom), pick_priority());
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (fails == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
